FILE: hdl/bgi_pkg.sv
// Shared types and constants for the bilinear grid interpolator.
package bgi_pkg;

    typedef enum logic [1:0] {
        OP_WR_X = 2'd0,
        OP_WR_Y = 2'd1,
        OP_WR_GRID = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    localparam int FRAC_BITS = 16;
    localparam logic [6:0] MIN_KNOTS = 7'd2;
    localparam logic [0:0] REG_X_USED = 1'b0;
    localparam logic [0:0] REG_Y_USED = 1'b1;

    typedef struct packed {
        op_t op;
        logic [5:0] row_index;
        logic [5:0] col_index;
        logic signed [31:0] write_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic saturated;
        logic used_nearest;
    } result_t;

endpackage

FILE: hdl/bgi_front.sv
// Input stage of the interpolator: accepts items and holds them in a short queue.
module bgi_front import bgi_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  q_valid,
    input  logic  q_ready,
    output item_t q_item
);
    item_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: hdl/bgi_back.sv
// Execution stage: knot and grid stores, bracket search, division and blending.
module bgi_back import bgi_pkg::*; #(
    parameter int MAX_X_KNOTS = 64,
    parameter int MAX_Y_KNOTS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [6:0] x_used,
    input  logic [6:0] y_used,
    input  logic       q_valid,
    output logic       q_ready,
    input  item_t      q_item,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);
    localparam int XW = $clog2(MAX_X_KNOTS);
    localparam int YW = $clog2(MAX_Y_KNOTS);
    localparam int GD = MAX_X_KNOTS * MAX_Y_KNOTS;
    localparam int GW = XW + YW;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_X, S_SRCH_Y, S_KNOT, S_CHK, S_GRID, S_DIV, S_LERP_A,
        S_LERP_B, S_LERP_C, S_OUT
    } state_t;

    logic signed [31:0] xmem [MAX_X_KNOTS];
    logic signed [31:0] ymem [MAX_Y_KNOTS];
    logic signed [31:0] gmem [GD];

    state_t state_reg;
    item_t it_reg;
    logic [10:0] nx_reg, ny_reg, k_reg;
    logic [10:0] ix_reg, iy_reg;
    logic [1:0] sub_reg;
    logic signed [31:0] xr_reg, yr_reg, gr_reg;
    logic [XW-1:0] xa_reg;
    logic [YW-1:0] ya_reg;
    logic [GW-1:0] ga_reg;
    logic signed [31:0] x1_reg, y1_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [31:0] v11_reg, v12_reg, v21_reg, v22_reg;
    // division: magnitude restoring divider over 49-bit numerator
    logic [48:0] quo_reg;
    logic [32:0] rem_reg, den_reg;
    logic neg_reg, dsel_reg;
    logic [5:0] dcnt_reg;
    logic signed [31:0] tx_reg, ty_reg, r1_reg, r2_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] base_reg;
    logic clip_reg, near_reg;
    result_t res_reg;

    // search probe values: one read port per store
    always_ff @(posedge aclk) begin
        xr_reg <= xmem[xa_reg];
        yr_reg <= ymem[ya_reg];
        gr_reg <= gmem[ga_reg];
        if (state_reg == S_IDLE && q_valid) begin
            unique case (q_item.op)
                OP_WR_X: if (32'(q_item.row_index) < MAX_X_KNOTS)
                    xmem[q_item.row_index[XW-1:0]] <= q_item.write_value;
                OP_WR_Y: if (32'(q_item.col_index) < MAX_Y_KNOTS)
                    ymem[q_item.col_index[YW-1:0]] <= q_item.write_value;
                OP_WR_GRID: if (32'(q_item.row_index) < MAX_X_KNOTS &&
                                32'(q_item.col_index) < MAX_Y_KNOTS)
                    gmem[{q_item.row_index[XW-1:0], q_item.col_index[YW-1:0]}]
                        <= q_item.write_value;
                default: ;
            endcase
        end
    end

    assign q_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_res = res_reg;

    function automatic logic [10:0] eff(input logic [6:0] r, input int mx);
        if (r < MIN_KNOTS) return 11'd2;
        if (32'(r) > mx) return 11'(mx);
        return {4'd0, r};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                 output logic c);
        c = 1'b0;
        if (v > 66'sd2147483647) begin c = 1'b1; return 32'sh7fffffff; end
        if (v < -66'sd2147483648) begin c = 1'b1; return 32'sh80000000; end
        return v[31:0];
    endfunction

    logic signed [65:0] fl_sum;
    logic signed [31:0] sat_val;
    logic sat_c;
    logic [33:0] trial;
    logic signed [49:0] tq;
    logic signed [31:0] tsat;
    logic tclip;
    logic [10:0] clamp_k;
    logic signed [32:0] dcur;

    always_comb begin
        // arithmetic shift equals floor division by 2^16
        fl_sum = 66'(base_reg) + (prod_reg >>> FRAC_BITS);
        sat_val = sat32(fl_sum, sat_c);
        trial = {rem_reg, quo_reg[48]} - {1'b0, den_reg};
        tq = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        tclip = 1'b0;
        if (tq > 50'sd1073741824) begin tsat = 32'sd1073741824; tclip = 1'b1; end
        else if (tq < -50'sd1073741824) begin
            tsat = -32'sd1073741824; tclip = 1'b1;
        end else tsat = tq[31:0];
        clamp_k = (k_reg == 11'd0) ? 11'd1 : k_reg;
        dcur = dsel_reg ? dy_reg : dx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: if (q_valid) begin
                    it_reg <= q_item;
                    res_reg <= '0;
                    if (q_item.op == OP_QUERY) begin
                        nx_reg <= eff(x_used, MAX_X_KNOTS);
                        ny_reg <= eff(y_used, MAX_Y_KNOTS);
                        k_reg <= '0;
                        xa_reg <= '0;
                        sub_reg <= 2'd0;
                        state_reg <= S_SRCH_X;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                // linear scan: each knot takes an address step, then a compare step
                S_SRCH_X: begin
                    if (sub_reg == 2'd0) sub_reg <= 2'd1;
                    else if (k_reg < nx_reg && xr_reg < it_reg.query_x) begin
                        k_reg <= k_reg + 11'd1;
                        xa_reg <= XW'(k_reg + 11'd1);
                        sub_reg <= 2'd0;
                    end else begin
                        ix_reg <= (clamp_k >= nx_reg) ? nx_reg - 11'd1 : clamp_k;
                        k_reg <= '0;
                        ya_reg <= '0;
                        sub_reg <= 2'd0;
                        state_reg <= S_SRCH_Y;
                    end
                end
                S_SRCH_Y: begin
                    if (sub_reg == 2'd0) sub_reg <= 2'd1;
                    else if (k_reg < ny_reg && yr_reg < it_reg.query_y) begin
                        k_reg <= k_reg + 11'd1;
                        ya_reg <= YW'(k_reg + 11'd1);
                        sub_reg <= 2'd0;
                    end else begin
                        iy_reg <= (clamp_k >= ny_reg) ? ny_reg - 11'd1 : clamp_k;
                        xa_reg <= XW'(ix_reg - 11'd1);
                        ya_reg <= YW'(((clamp_k >= ny_reg) ? ny_reg - 11'd1
                                                            : clamp_k) - 11'd1);
                        sub_reg <= 2'd0;
                        state_reg <= S_KNOT;
                    end
                end
                S_KNOT: begin
                    sub_reg <= sub_reg + 2'd1;
                    if (sub_reg == 2'd1) begin
                        x1_reg <= xr_reg;
                        y1_reg <= yr_reg;
                        xa_reg <= XW'(ix_reg);
                        ya_reg <= YW'(iy_reg);
                    end else if (sub_reg == 2'd3) begin
                        dx_reg <= 33'(xr_reg) - 33'(x1_reg);
                        dy_reg <= 33'(yr_reg) - 33'(y1_reg);
                        ga_reg <= {XW'(ix_reg - 11'd1), YW'(iy_reg - 11'd1)};
                        sub_reg <= 2'd0;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    sub_reg <= sub_reg + 2'd1;
                    if (sub_reg == 2'd1) begin
                        if (dx_reg == '0 || dy_reg == '0) begin
                            res_reg.result_value <= gr_reg;
                            res_reg.used_nearest <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            v11_reg <= gr_reg;
                            ga_reg <= {XW'(ix_reg - 11'd1), YW'(iy_reg)};
                            sub_reg <= 2'd0;
                            state_reg <= S_GRID;
                        end
                    end
                end
                S_GRID: begin
                    sub_reg <= sub_reg + 2'd1;
                    unique case (sub_reg)
                        2'd0: ga_reg <= {XW'(ix_reg), YW'(iy_reg - 11'd1)};
                        2'd1: begin
                            ga_reg <= {XW'(ix_reg), YW'(iy_reg)};
                            v12_reg <= gr_reg;
                        end
                        2'd2: v21_reg <= gr_reg;
                        default: ;
                    endcase
                    if (sub_reg == 2'd3) begin
                        clip_reg <= 1'b0;
                        dsel_reg <= 1'b0;
                        state_reg <= S_DIV;
                        dcnt_reg <= 6'd0;
                    end
                end
                S_DIV: begin
                    if (dcnt_reg == 6'd0) begin
                        if (!dsel_reg) v22_reg <= gr_reg;
                        begin : setup
                            logic signed [32:0] a;
                            logic [48:0] an;
                            logic [32:0] dm;
                            a = dsel_reg ? 33'(it_reg.query_y) - 33'(y1_reg)
                                         : 33'(it_reg.query_x) - 33'(x1_reg);
                            an = a[32] ? 49'(-a) << FRAC_BITS : 49'(a) << FRAC_BITS;
                            dm = dcur[32] ? 33'(-dcur) : 33'(dcur);
                            quo_reg <= an;
                            den_reg <= dm;
                            neg_reg <= a[32] ^ dcur[32];
                        end
                        rem_reg <= '0;
                        dcnt_reg <= 6'd1;
                    end else if (dcnt_reg <= 6'd49) begin
                        if (!trial[33]) begin
                            rem_reg <= trial[32:0];
                            quo_reg <= {quo_reg[47:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[31:0], quo_reg[48]};
                            quo_reg <= {quo_reg[47:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg + 6'd1;
                    end else begin
                        clip_reg <= clip_reg | tclip;
                        dcnt_reg <= 6'd0;
                        if (!dsel_reg) begin
                            tx_reg <= tsat;
                            dsel_reg <= 1'b1;
                        end else begin
                            ty_reg <= tsat;
                            base_reg <= v11_reg;
                            prod_reg <= (66'(v12_reg) - 66'(v11_reg)) * 66'(tsat);
                            state_reg <= S_LERP_A;
                        end
                    end
                end
                S_LERP_A: begin
                    r1_reg <= sat_val;
                    clip_reg <= clip_reg | sat_c;
                    base_reg <= v21_reg;
                    prod_reg <= (66'(v22_reg) - 66'(v21_reg)) * 66'(ty_reg);
                    state_reg <= S_LERP_B;
                end
                S_LERP_B: begin
                    r2_reg <= sat_val;
                    clip_reg <= clip_reg | sat_c;
                    base_reg <= r1_reg;
                    prod_reg <= (66'(sat_val) - 66'(r1_reg)) * 66'(tx_reg);
                    state_reg <= S_LERP_C;
                end
                S_LERP_C: begin
                    res_reg.result_value <= sat_val;
                    res_reg.saturated <= clip_reg | sat_c;
                    state_reg <= S_OUT;
                end
                S_OUT: if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/bilinear_grid_interpolator_core.sv
// Top level of the bilinear grid interpolator: ports, registers and checks.
//
// Items arrive on the s_ stream: op 0 and 1 write an x or y knot, op 2 writes
// a grid value, op 3 queries the point (query_x, query_y). Every item yields
// exactly one result on the m_ stream; writes return zero.
// Knot counts are set through the APB port (x at address 0, y at 4) and must
// only be changed while no item is in flight.
// A two-entry queue sits in front of the execution unit, so up to two items
// are taken while the unit is busy or the receiver stalls.
// A write passes from the idle state straight to the output state. A query
// scans the knots linearly, one knot at a time on each axis, then reads the
// knots and grid values and runs two 49-step serial divisions and three lerps.
// The serial divider and the one-knot-per-step scan set the rate.
// The result is held on m_tdata until m_tready; nothing is lost on stall.
// Reset sets both knot counts to 2 and empties the queue; stores are not
// cleared and must be written before they are read.
module bilinear_grid_interpolator_core import bgi_pkg::*; #(
    parameter int MAX_X_KNOTS = 64,
    parameter int MAX_Y_KNOTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[1:0], row_index[7:2], col_index[13:8], write_value[45:14],
    // query_x[77:46], query_y[109:78], zero fill to 112
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_value[31:0]
    output logic [31:0]  m_tdata,
    // saturated[0], used_nearest[1]
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [6:0] x_used_reg, y_used_reg;
    item_t in_item, q_item;
    logic q_valid, q_ready;
    result_t res;

    assign in_item.op = op_t'(s_tdata[1:0]);
    assign in_item.row_index = s_tdata[7:2];
    assign in_item.col_index = s_tdata[13:8];
    assign in_item.write_value = s_tdata[45:14];
    assign in_item.query_x = s_tdata[77:46];
    assign in_item.query_y = s_tdata[109:78];

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_Y_USED) ? {25'd0, y_used_reg} : {25'd0, x_used_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_used_reg <= MIN_KNOTS;
            y_used_reg <= MIN_KNOTS;
        end else if (psel && penable && pwrite) begin
            if (paddr == 3'd0) x_used_reg <= pwdata[6:0];
            else if (paddr == 3'd4) y_used_reg <= pwdata[6:0];
        end
    end

    bgi_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
        .q_valid, .q_ready, .q_item
    );

    bgi_back #(.MAX_X_KNOTS(MAX_X_KNOTS), .MAX_Y_KNOTS(MAX_Y_KNOTS)) u_back (
        .aclk, .aresetn,
        .x_used(x_used_reg), .y_used(y_used_reg),
        .q_valid, .q_ready, .q_item,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = res.result_value;
    assign m_tuser = {res.used_nearest, res.saturated};

    a_near_no_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0]) else $error("nearest with clip");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    a_cfg_reset: assert property (@(posedge aclk)
        !aresetn |=> x_used_reg == MIN_KNOTS && y_used_reg == MIN_KNOTS)
        else $error("knot count reset");
endmodule

FILE: sim/bilinear_grid_interpolator_core_tb.sv
// Self-checking testbench for the bilinear grid interpolator core.
`timescale 1ns / 1ps

module bilinear_grid_interpolator_core_tb;
    import bgi_pkg::*;

    localparam int NX_MAX = 64;
    localparam int NY_MAX = 64;
    localparam logic [2:0] ADDR_X_USED = 3'd0;
    localparam logic [2:0] ADDR_Y_USED = 3'd4;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // op, row_index, col_index, write_value, query_x, query_y from bit 0 up
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // result_value
    logic [31:0]  m_tdata;
    // saturated, used_nearest
    logic [1:0]   m_tuser;
    logic         psel, penable, pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    bilinear_grid_interpolator_core dut (.*);

    // Predictor state.
    logic signed [31:0] xk [NX_MAX];
    logic signed [31:0] yk [NY_MAX];
    logic signed [31:0] grid [NX_MAX*NY_MAX];
    logic [6:0] nx_reg, ny_reg;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      n_errors = 0;
    int      n_results = 0;
    int      n_queries = 0;
    int      n_nearest = 0;
    int      n_sat = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint clip_to(longint v, longint lo, longint hi, ref bit c);
        if (v < lo) begin
            c = 1;
            return lo;
        end
        if (v > hi) begin
            c = 1;
            return hi;
        end
        return v;
    endfunction

    function automatic longint lerp_q16(longint p, longint q, longint t, ref bit c);
        longint prod;
        longint r;
        prod = (q - p) * t;
        r = (prod >= 0) ? prod / 65536 : -((-prod + 65535) / 65536);
        return clip_to(p + r, -64'sd2147483648, 64'sd2147483647, c);
    endfunction

    function automatic int knot_count(logic [6:0] r, int mx);
        if (r < 2) return 2;
        if (r > mx) return mx;
        return int'(r);
    endfunction

    function automatic result_t interpolate(item_t it);
        result_t r;
        bit c;
        int nx, ny, i2, j2;
        longint x1, x2, y1, y2, qx, qy, v11, v12, v21, v22, tx, ty, r1, r2;
        r = '0;
        c = 0;
        case (it.op)
            OP_WR_X: xk[it.row_index] = it.write_value;
            OP_WR_Y: yk[it.col_index] = it.write_value;
            OP_WR_GRID: grid[it.row_index*NY_MAX + it.col_index] = it.write_value;
            OP_QUERY: begin
                qx = it.query_x;
                qy = it.query_y;
                nx = knot_count(nx_reg, NX_MAX);
                ny = knot_count(ny_reg, NY_MAX);
                i2 = 0;
                while (i2 < nx && longint'(xk[i2]) < qx) i2++;
                if (i2 == 0) i2 = 1;
                if (i2 >= nx) i2 = nx - 1;
                j2 = 0;
                while (j2 < ny && longint'(yk[j2]) < qy) j2++;
                if (j2 == 0) j2 = 1;
                if (j2 >= ny) j2 = ny - 1;
                x1 = xk[i2-1];
                x2 = xk[i2];
                y1 = yk[j2-1];
                y2 = yk[j2];
                v11 = grid[(i2-1)*NY_MAX + j2-1];
                if (x1 == x2 || y1 == y2) begin
                    r.result_value = 32'(v11);
                    r.used_nearest = 1'b1;
                end else begin
                    v12 = grid[(i2-1)*NY_MAX + j2];
                    v21 = grid[i2*NY_MAX + j2-1];
                    v22 = grid[i2*NY_MAX + j2];
                    tx = clip_to(((qx - x1) * 65536) / (x2 - x1), -(64'sd1 << 30),
                                 64'sd1 << 30, c);
                    ty = clip_to(((qy - y1) * 65536) / (y2 - y1), -(64'sd1 << 30),
                                 64'sd1 << 30, c);
                    r1 = lerp_q16(v11, v12, ty, c);
                    r2 = lerp_q16(v21, v22, ty, c);
                    r.result_value = 32'(lerp_q16(r1, r2, tx, c));
                    r.saturated = c;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [111:0] pack_item(item_t it);
        return {2'b00, it.query_y, it.query_x, it.write_value, it.col_index,
                it.row_index, it.op};
    endfunction

    // Driver; the prediction is made at acceptance in the same process.
    int s_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(interpolate(item_t'({s_tdata[1:0],
                    s_tdata[7:2], s_tdata[13:8], s_tdata[45:14], s_tdata[77:46],
                    s_tdata[109:78]})));
                void'(pending_items.pop_front());
                s_gap = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) s_gap = 0;
            end
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 0;
            end else if (pending_items.size() > 0) begin
                s_tvalid <= 1;
                s_tdata <= pack_item(pending_items[0]);
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // Monitor and receiver stalls.
    int m_gap = 0;
    always @(posedge aclk) begin
        result_t e;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("result with no expectation: %h", m_tdata);
                    n_errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata !== e.result_value) begin
                        $error("result_value expected %h actual %h", e.result_value, m_tdata);
                        n_errors++;
                    end
                    if (m_tuser[0] !== e.saturated) begin
                        $error("saturated expected %b actual %b", e.saturated, m_tuser[0]);
                        n_errors++;
                    end
                    if (m_tuser[1] !== e.used_nearest) begin
                        $error("used_nearest expected %b actual %b", e.used_nearest,
                               m_tuser[1]);
                        n_errors++;
                    end
                    n_nearest += e.used_nearest;
                    n_sat += e.saturated;
                end
                m_gap = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) m_gap = 0;
            end
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (addr == ADDR_X_USED) nx_reg = data[6:0];
        else nx_reg = nx_reg;
        if (addr == ADDR_Y_USED) ny_reg = data[6:0];
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic push_item(op_t op, int row, int col, logic [31:0] wv,
                             logic [31:0] qx, logic [31:0] qy);
        item_t it;
        it.op = op;
        it.row_index = 6'(row);
        it.col_index = 6'(col);
        it.write_value = wv;
        it.query_x = qx;
        it.query_y = qy;
        if (op == OP_QUERY) n_queries++;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] rand32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 65536*8) - 65536*4;
            default: return $urandom;
        endcase
    endfunction

    // Loads sorted (occasionally duplicated) knots and the grid in use.
    task automatic load_tables(int n_x, int n_y, bit wide);
        logic signed [31:0] v;
        int stepmax;
        stepmax = wide ? 32'h0100_0000 : 32'h0004_0000;
        v = wide ? -32'sh4000_0000 : $urandom_range(0, 65536*8) - 65536*4;
        for (int i = 0; i < n_x; i++) begin
            push_item(OP_WR_X, i, $urandom_range(0, 63), v, $urandom, $urandom);
            if ($urandom_range(0, 15) != 0) v = v + $urandom_range(1, stepmax);
        end
        v = wide ? -32'sh4000_0000 : $urandom_range(0, 65536*8) - 65536*4;
        for (int j = 0; j < n_y; j++) begin
            push_item(OP_WR_Y, $urandom_range(0, 63), j, v, $urandom, $urandom);
            if ($urandom_range(0, 15) != 0) v = v + $urandom_range(1, stepmax);
        end
        for (int i = 0; i < n_x; i++)
            for (int j = 0; j < n_y; j++)
                push_item(OP_WR_GRID, i, j, wide ? rand32()
                          : $urandom_range(0, 65536*200) - 65536*100, $urandom, $urandom);
    endtask

    task automatic run_queries(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                push_item(OP_QUERY, $urandom, $urandom, $urandom, rand32(), rand32());
            else
                push_item(OP_QUERY, $urandom, $urandom, $urandom,
                          $urandom_range(0, 65536*40) - 65536*20,
                          $urandom_range(0, 65536*40) - 65536*20);
        end
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        nx_reg = 7'd2;
        ny_reg = 7'd2;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: two x knots and all y knots defined, then extreme queries.
        load_tables(2, NY_MAX, 1);
        wait_idle();
        apb_write(ADDR_X_USED, 32'd2);
        apb_write(ADDR_Y_USED, 32'd64);
        push_item(OP_QUERY, 0, 0, 0, 32'h8000_0000, 32'h8000_0000);
        push_item(OP_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_item(OP_QUERY, 63, 63, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_item(OP_QUERY, 0, 0, 0, 0, 0);
        // Repeated knots: the first two knots of each axis are set equal.
        push_item(OP_WR_X, 1, 0, 32'hC000_0000, 0, 0);
        push_item(OP_WR_Y, 0, 1, 32'hC000_0000, 0, 0);
        push_item(OP_QUERY, 0, 0, 0, 32'hC100_0000, 32'h8000_0000);
        // Equal knots force the corner value.
        push_item(OP_WR_X, 1, 0, 32'hC000_0000, 0, 0);
        push_item(OP_WR_X, 0, 0, 32'hC000_0000, 0, 0);
        push_item(OP_QUERY, 0, 0, 0, 32'h8000_0000, 32'h0);
        wait_idle();
        // Counts below the minimum and above the maximum.
        apb_write(ADDR_X_USED, 32'd0);
        apb_write(ADDR_Y_USED, 32'd127);
        push_item(OP_QUERY, 0, 0, 0, 32'h0001_0000, 32'hFFFF_0000);
        push_item(OP_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_idle();
        apb_write(ADDR_X_USED, 32'd1);
        apb_write(ADDR_Y_USED, 32'd65);
        push_item(OP_QUERY, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_idle();

        // Random phases over several knot counts.
        for (int ph = 0; ph < 6; ph++) begin
            int cx, cy;
            cx = (ph == 0) ? 2 : (ph == 1) ? 64 : $urandom_range(2, 12);
            cy = (ph == 0) ? 64 : (ph == 1) ? 2 : $urandom_range(2, 12);
            if (ph == 5) begin
                cx = $urandom_range(0, 3);
                cy = $urandom_range(65, 127);
            end
            apb_write(ADDR_X_USED, cx);
            apb_write(ADDR_Y_USED, cy);
            load_tables(knot_count(7'(cx), NX_MAX), knot_count(7'(cy), NY_MAX), ph == 4);
            run_queries(40);
            wait_idle();
        end
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Checked %0d results, %0d queries (%0d nearest-corner, %0d clipped).",
                 n_results, n_queries, n_nearest, n_sat);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("PASS bilinear_grid_interpolator_core");
        else
            $display("FAIL bilinear_grid_interpolator_core");
        $finish;
    end

    initial begin
        #200ms;
        $display("FAIL bilinear_grid_interpolator_core");
        $finish;
    end

endmodule
